[hw/rtl/vrot_pkg.sv]
// Shared types, constants and rounding helper for the vector rotation core.
// No dependencies; used by every module under hw/rtl.
`default_nettype none

package vrot_pkg;

    localparam int ANGLE_W             = 12;
    localparam int ANGLE_BITS          = 12;
    localparam int QUARTER_TABLE_DEPTH = 1024;
    localparam int OP_W                = 2;
    localparam int COORD_W             = 32;
    localparam int SINE_W              = 17;
    localparam int TRIG_W              = SINE_W + 1;
    localparam int PROD_W              = COORD_W + TRIG_W;
    localparam int ROUND_SHIFT         = 15;
    localparam int SHIFTED_W           = PROD_W + 1 - ROUND_SHIFT;
    localparam int S_TDATA_W           = 112;
    localparam int M_TDATA_W           = 96;

    typedef enum logic [OP_W-1:0] {
        AXIS_X    = 2'd0,
        AXIS_Y    = 2'd1,
        AXIS_Z    = 2'd2,
        AXIS_PASS = 2'd3
    } t_axis_op;

    typedef struct packed {
        t_axis_op                   op;
        logic [1:0]                 quad;
        logic signed [COORD_W-1:0]  x;
        logic signed [COORD_W-1:0]  y;
        logic signed [COORD_W-1:0]  z;
    } t_stage_a;

    typedef struct packed {
        t_axis_op                   op;
        logic signed [COORD_W-1:0]  x;
        logic signed [COORD_W-1:0]  y;
        logic signed [COORD_W-1:0]  z;
        logic signed [PROD_W-1:0]   pa_c;
        logic signed [PROD_W-1:0]   pb_s;
        logic signed [PROD_W-1:0]   pa_s;
        logic signed [PROD_W-1:0]   pb_c;
    } t_stage_mul;

    typedef struct packed {
        t_axis_op                   op;
        logic signed [COORD_W-1:0]  x;
        logic signed [COORD_W-1:0]  y;
        logic signed [COORD_W-1:0]  z;
        logic                       clip;
    } t_stage_out;

    typedef struct packed {
        logic signed [COORD_W-1:0]  value;
        logic                       clip;
    } t_sat;

    // (pa +/- pb) >> 15, round half up, saturated to 32 bits
    function automatic t_sat mix_round(input logic signed [PROD_W-1:0] pa,
                                       input logic signed [PROD_W-1:0] pb,
                                       input logic                     sub);
        logic [PROD_W:0]    pa_ext;
        logic [PROD_W:0]    pb_ext;
        logic [PROD_W:0]    acc;
        logic [SHIFTED_W-1:0] r;
        t_sat               res;
        pa_ext = {pa[PROD_W-1], pa};
        pb_ext = {pb[PROD_W-1], pb};
        acc = (sub ? (pa_ext - pb_ext) : (pa_ext + pb_ext))
            + ((PROD_W + 1)'(1) << (ROUND_SHIFT - 1));
        r = acc[PROD_W:ROUND_SHIFT];
        if ((&r[SHIFTED_W-1:COORD_W-1]) || !(|r[SHIFTED_W-1:COORD_W-1])) begin
            res.value = r[COORD_W-1:0];
            res.clip  = 1'b0;
        end else begin
            res.value = r[SHIFTED_W-1] ? {1'b1, {(COORD_W-1){1'b0}}}
                                       : {1'b0, {(COORD_W-1){1'b1}}};
            res.clip  = 1'b1;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/vec3_axis_rotation_core.sv]
// Rotates a signed Q16.16 3-vector about X, Y or Z by a binary angle
// (4096 units per turn; selector 3 passes the vector through). One vector
// is accepted every cycle unless an output stall has backed up to the input.
// The input register with the sine ROM read register beside it, the
// multiplier register and the output register form a chain of three cells;
// a stall on the output backs up only through the cells that are full. The
// sine table is constant, so there is no start-up fill. Top level; depends on vrot_pkg, vrot_cell, vrot_sine_rom.
`default_nettype none

module vec3_axis_rotation_core #(
    parameter int QUARTER_TABLE_DEPTH = vrot_pkg::QUARTER_TABLE_DEPTH
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // turn_angle[11:0], in_x[43:12], in_y[75:44], in_z[107:76], zero pad
    input  wire logic [vrot_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // op[1:0]
    input  wire logic [vrot_pkg::OP_W-1:0]      s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // out_x[31:0], out_y[63:32], out_z[95:64]
    output logic [vrot_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    // clipped[0]
    output logic                                m_axis_tuser
);

    localparam int IdxW = $clog2(QUARTER_TABLE_DEPTH + 1);
    localparam int PosW = vrot_pkg::ANGLE_BITS - 2;
    localparam int ScW  = PosW + IdxW + 1;
    localparam int CW   = vrot_pkg::COORD_W;

    logic [vrot_pkg::ANGLE_BITS-1:0] ang;
    logic [PosW-1:0]                 pos;
    logic [ScW-1:0]                  scaled;
    logic [IdxW:0]                   idx_full;
    logic [IdxW-1:0]                 idx_lo;
    logic [IdxW-1:0]                 idx_hi;
    logic                            rom_en;
    logic [vrot_pkg::SINE_W-1:0]     sin_lo;
    logic [vrot_pkg::SINE_W-1:0]     sin_hi;

    vrot_pkg::t_stage_a   stage_a_in;
    vrot_pkg::t_stage_a   stage_a;
    vrot_pkg::t_stage_mul stage_mul_in;
    vrot_pkg::t_stage_mul stage_mul;
    vrot_pkg::t_stage_out stage_out_in;
    vrot_pkg::t_stage_out stage_out;

    logic a_valid, a_ready_dn;
    logic mul_valid, mul_ready_dn;

    logic signed [vrot_pkg::TRIG_W-1:0] lo_s, hi_s, sin_v, cos_v;
    logic signed [CW-1:0]               op_a, op_b;
    vrot_pkg::t_sat                     res_u, res_v;

    // angle to table index
    assign ang      = s_axis_tdata[vrot_pkg::ANGLE_BITS-1:0];
    assign pos      = ang[PosW-1:0];
    assign scaled   = ScW'(pos) * ScW'(QUARTER_TABLE_DEPTH) + (ScW'(1) << (PosW - 1));
    assign idx_full = scaled[ScW-1:PosW];
    assign idx_lo   = (idx_full > (IdxW + 1)'(QUARTER_TABLE_DEPTH))
                    ? IdxW'(QUARTER_TABLE_DEPTH) : idx_full[IdxW-1:0];
    assign idx_hi   = IdxW'(QUARTER_TABLE_DEPTH) - idx_lo;
    assign rom_en   = s_axis_tvalid && s_axis_tready;

    always_comb begin
        stage_a_in.op   = vrot_pkg::t_axis_op'(s_axis_tuser);
        stage_a_in.quad = ang[vrot_pkg::ANGLE_BITS-1:vrot_pkg::ANGLE_BITS-2];
        stage_a_in.x    = s_axis_tdata[12 +: CW];
        stage_a_in.y    = s_axis_tdata[44 +: CW];
        stage_a_in.z    = s_axis_tdata[76 +: CW];
    end

    vrot_sine_rom #(
        .QUARTER_TABLE_DEPTH(QUARTER_TABLE_DEPTH)
    ) u_rom (
        .i_clk    (i_clk),
        .i_en     (rom_en),
        .i_addr_lo(idx_lo),
        .i_addr_hi(idx_hi),
        .o_lo     (sin_lo),
        .o_hi     (sin_hi)
    );

    vrot_cell #(
        .WIDTH($bits(vrot_pkg::t_stage_a))
    ) u_cell_a (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid),
        .o_ready(s_axis_tready),
        .i_data (stage_a_in),
        .o_valid(a_valid),
        .i_ready(a_ready_dn),
        .o_data (stage_a)
    );

    // quadrant fold and products
    always_comb begin
        lo_s = $signed({1'b0, sin_lo});
        hi_s = $signed({1'b0, sin_hi});
        case (stage_a.quad)
            2'd0: begin
                sin_v = lo_s;
                cos_v = hi_s;
            end
            2'd1: begin
                sin_v = hi_s;
                cos_v = -lo_s;
            end
            2'd2: begin
                sin_v = -lo_s;
                cos_v = -hi_s;
            end
            default: begin
                sin_v = -hi_s;
                cos_v = lo_s;
            end
        endcase
        case (stage_a.op)
            vrot_pkg::AXIS_X: begin
                op_a = stage_a.y;
                op_b = stage_a.z;
            end
            vrot_pkg::AXIS_Y: begin
                op_a = stage_a.x;
                op_b = stage_a.z;
            end
            default: begin
                op_a = stage_a.x;
                op_b = stage_a.y;
            end
        endcase
        stage_mul_in.op   = stage_a.op;
        stage_mul_in.x    = stage_a.x;
        stage_mul_in.y    = stage_a.y;
        stage_mul_in.z    = stage_a.z;
        stage_mul_in.pa_c = op_a * cos_v;
        stage_mul_in.pb_s = op_b * sin_v;
        stage_mul_in.pa_s = op_a * sin_v;
        stage_mul_in.pb_c = op_b * cos_v;
    end

    vrot_cell #(
        .WIDTH($bits(vrot_pkg::t_stage_mul))
    ) u_cell_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(a_valid),
        .o_ready(a_ready_dn),
        .i_data (stage_mul_in),
        .o_valid(mul_valid),
        .i_ready(mul_ready_dn),
        .o_data (stage_mul)
    );

    // sum, round, saturate, route
    always_comb begin
        res_u = vrot_pkg::mix_round(stage_mul.pa_c, stage_mul.pb_s, 1'b1);
        res_v = vrot_pkg::mix_round(stage_mul.pa_s, stage_mul.pb_c, 1'b0);
        stage_out_in.op   = stage_mul.op;
        stage_out_in.x    = stage_mul.x;
        stage_out_in.y    = stage_mul.y;
        stage_out_in.z    = stage_mul.z;
        stage_out_in.clip = 1'b0;
        case (stage_mul.op)
            vrot_pkg::AXIS_X: begin
                stage_out_in.y    = res_u.value;
                stage_out_in.z    = res_v.value;
                stage_out_in.clip = res_u.clip || res_v.clip;
            end
            vrot_pkg::AXIS_Y: begin
                stage_out_in.x    = res_u.value;
                stage_out_in.z    = res_v.value;
                stage_out_in.clip = res_u.clip || res_v.clip;
            end
            vrot_pkg::AXIS_Z: begin
                stage_out_in.x    = res_u.value;
                stage_out_in.y    = res_v.value;
                stage_out_in.clip = res_u.clip || res_v.clip;
            end
            default: begin
                stage_out_in.clip = 1'b0;
            end
        endcase
    end

    vrot_cell #(
        .WIDTH($bits(vrot_pkg::t_stage_out))
    ) u_cell_out (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(mul_valid),
        .o_ready(mul_ready_dn),
        .i_data (stage_out_in),
        .o_valid(m_axis_tvalid),
        .i_ready(m_axis_tready),
        .o_data (stage_out)
    );

    assign m_axis_tdata = {stage_out.z, stage_out.y, stage_out.x};
    assign m_axis_tuser = stage_out.clip;

    // an empty output cell lets the whole chain move
    a_ready_when_out_empty: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready
    ) else $error("input stalled with empty output cell");

    // a stalled multiplier cell keeps its beat
    a_mul_hold: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        mul_valid && !mul_ready_dn |=> mul_valid && $stable(stage_mul)
    ) else $error("multiplier beat lost or changed during stall");

    // pass-through never reports saturation
    a_pass_no_clip: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (stage_out.op == vrot_pkg::AXIS_PASS) |-> !m_axis_tuser
    ) else $error("clip flagged on pass-through beat");

endmodule

`default_nettype wire

[hw/rtl/vrot_cell.sv]
// One pipeline cell: holds a beat and hands it to the next cell when it can.
// Depends on vrot_pkg for the default width.
`default_nettype none

module vrot_cell #(
    parameter int WIDTH = $bits(vrot_pkg::t_stage_a)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic [WIDTH-1:0]      o_data
);

    logic             r_valid;
    logic             n_valid;
    logic [WIDTH-1:0] r_data;
    logic             load;

    assign o_ready = !r_valid || i_ready;
    assign load    = i_valid && o_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        if (load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data <= i_data;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/vrot_sine_rom.sv]
// Quarter-wave sine ROM in Q2.15, two registered read ports.
// Contents built at elaboration; depends on vrot_pkg.
`default_nettype none

module vrot_sine_rom #(
    parameter int QUARTER_TABLE_DEPTH = vrot_pkg::QUARTER_TABLE_DEPTH
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_en,
    input  wire logic [$clog2(QUARTER_TABLE_DEPTH+1)-1:0] i_addr_lo,
    input  wire logic [$clog2(QUARTER_TABLE_DEPTH+1)-1:0] i_addr_hi,
    output logic [vrot_pkg::SINE_W-1:0]                o_lo,
    output logic [vrot_pkg::SINE_W-1:0]                o_hi
);

    localparam logic [63:0] PiHalfQ40 = 64'd1727108826180;
    localparam logic [63:0] AngleDen  = 64'(QUARTER_TABLE_DEPTH) << 10;
    localparam logic [63:0] AngleBias = 64'(QUARTER_TABLE_DEPTH) << 9;
    localparam logic [63:0] HalfQ30   = 64'd1 << 29;

    typedef logic [vrot_pkg::SINE_W-1:0] t_rom [0:QUARTER_TABLE_DEPTH];

    // Taylor series to x^19 in Q30, rounded to Q15
    function automatic logic [vrot_pkg::SINE_W-1:0] sine_entry(input logic [63:0] i);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        x    = (PiHalfQ40 * i + AngleBias) / AngleDen;
        x2   = (x * x + HalfQ30) >> 30;
        term = x;
        sum  = x;
        term = (((term * x2 + HalfQ30) >> 30) + 64'd3) / 64'd6;
        sum  = sum - term;
        term = (((term * x2 + HalfQ30) >> 30) + 64'd10) / 64'd20;
        sum  = sum + term;
        term = (((term * x2 + HalfQ30) >> 30) + 64'd21) / 64'd42;
        sum  = sum - term;
        term = (((term * x2 + HalfQ30) >> 30) + 64'd36) / 64'd72;
        sum  = sum + term;
        term = (((term * x2 + HalfQ30) >> 30) + 64'd55) / 64'd110;
        sum  = sum - term;
        term = (((term * x2 + HalfQ30) >> 30) + 64'd78) / 64'd156;
        sum  = sum + term;
        term = (((term * x2 + HalfQ30) >> 30) + 64'd105) / 64'd210;
        sum  = sum - term;
        term = (((term * x2 + HalfQ30) >> 30) + 64'd136) / 64'd272;
        sum  = sum + term;
        term = (((term * x2 + HalfQ30) >> 30) + 64'd171) / 64'd342;
        sum  = sum - term;
        if (sum < 0) begin
            sum = 64'sd0;
        end
        return vrot_pkg::SINE_W'((64'(sum) + (64'd1 << 14)) >> 15);
    endfunction

    function automatic t_rom build_rom();
        t_rom rom;
        for (int i = 0; i <= QUARTER_TABLE_DEPTH; i++) begin
            rom[i] = sine_entry(64'(i));
        end
        return rom;
    endfunction

    localparam t_rom SineRom = build_rom();

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_lo <= SineRom[i_addr_lo];
            o_hi <= SineRom[i_addr_hi];
        end
    end

endmodule

`default_nettype wire

[test/tb_top.sv]
// Self-checking testbench for vec3_axis_rotation_core: directed table, then random vectors.
// Expected beats come from a local predictor with its own quarter-wave sine table,
// or from a directed row that states it. Depends on vrot_pkg and the RTL under hw/rtl.
`timescale 1ns / 1ps

module tb_top;

    localparam int RAND_ITEMS = 1800;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic signed [vrot_pkg::COORD_W-1:0] POS_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [vrot_pkg::COORD_W-1:0] NEG_MAX = 32'sh8000_0000;

    typedef struct packed {
        logic signed [vrot_pkg::COORD_W-1:0] x;
        logic signed [vrot_pkg::COORD_W-1:0] y;
        logic signed [vrot_pkg::COORD_W-1:0] z;
        logic                                clip;
    } t_rot_res;

    typedef struct {
        bit       known;
        t_rot_res res;
    } t_known_rot;

    typedef struct {
        vrot_pkg::t_axis_op                  op;
        logic [vrot_pkg::ANGLE_W-1:0]        ang;
        logic signed [vrot_pkg::COORD_W-1:0] x;
        logic signed [vrot_pkg::COORD_W-1:0] y;
        logic signed [vrot_pkg::COORD_W-1:0] z;
        bit                                  known;
        t_rot_res                            res;
    } t_stim_row;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [vrot_pkg::S_TDATA_W-1:0]   s_axis_tdata = '0;
    logic [vrot_pkg::OP_W-1:0]        s_axis_tuser = '0;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [vrot_pkg::M_TDATA_W-1:0]   m_axis_tdata;
    logic                             m_axis_tuser;

    int          sine_q15 [0:vrot_pkg::QUARTER_TABLE_DEPTH];
    t_rot_res    rotated_q [$];
    t_known_rot  known_rot_q [$];
    t_stim_row   dir_rows [20];
    int          fail_cnt = 0;
    int          cycle_cnt = 0;
    logic [9:0]  rx_cnt = '0;

    vec3_axis_rotation_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #1 i_clk = ~i_clk;

    // Q2.15 sine of (pi/2 * i / depth), Taylor series in Q30
    function automatic int sine_point(longint unsigned i);
        longint unsigned d, xr, x2, term, dv;
        longint          sum;
        d = 64'(vrot_pkg::QUARTER_TABLE_DEPTH);
        xr = (64'd1727108826180 * i + (d << 9)) / (d << 10);
        x2 = (xr * xr + (64'd1 << 29)) >> 30;
        term = xr;
        sum = xr;
        for (int k = 1; k <= 9; k++) begin
            dv = 64'((2 * k) * (2 * k + 1));
            term = (((term * x2 + (64'd1 << 29)) >> 30) + dv / 2) / dv;
            if (k & 1)
                sum -= term;
            else
                sum += term;
        end
        if (sum < 0)
            sum = 0;
        return int'(($unsigned(sum) + (64'd1 << 14)) >> 15);
    endfunction

    // (a*p + b*q) >> 15, round half up, saturated to 32 bits
    function automatic logic signed [vrot_pkg::COORD_W-1:0] mix_sat(longint a, longint p,
                                                                   longint b, longint q,
                                                                   inout logic clip);
        longint acc;
        acc = (a * p + b * q + 64'sd16384) >>> 15;
        if (acc > 64'sd2147483647) begin
            clip = 1'b1;
            return POS_MAX;
        end
        if (acc < -64'sd2147483648) begin
            clip = 1'b1;
            return NEG_MAX;
        end
        return acc[vrot_pkg::COORD_W-1:0];
    endfunction

    function automatic t_rot_res rotate_vec(vrot_pkg::t_axis_op op,
                                            logic [vrot_pkg::ANGLE_W-1:0] ang,
                                            logic signed [vrot_pkg::COORD_W-1:0] x,
                                            logic signed [vrot_pkg::COORD_W-1:0] y,
                                            logic signed [vrot_pkg::COORD_W-1:0] z);
        int unsigned full, quarter, a, quad, pos, idx;
        longint      s, c, lo, hi, xl, yl, zl;
        t_rot_res    r;
        full = 1 << vrot_pkg::ANGLE_BITS;
        quarter = full >> 2;
        a = ang & (full - 1);
        quad = a / quarter;
        pos = a % quarter;
        idx = (pos * vrot_pkg::QUARTER_TABLE_DEPTH + quarter / 2) / quarter;
        if (idx > vrot_pkg::QUARTER_TABLE_DEPTH)
            idx = vrot_pkg::QUARTER_TABLE_DEPTH;
        lo = longint'(sine_q15[idx]);
        hi = longint'(sine_q15[vrot_pkg::QUARTER_TABLE_DEPTH - idx]);
        xl = longint'(x);
        yl = longint'(y);
        zl = longint'(z);
        case (quad & 3)
            0: begin s = lo;  c = hi;  end
            1: begin s = hi;  c = -lo; end
            2: begin s = -lo; c = -hi; end
            default: begin s = -hi; c = lo; end
        endcase
        r.x = x;
        r.y = y;
        r.z = z;
        r.clip = 1'b0;
        case (op)
            vrot_pkg::AXIS_X: begin
                r.y = mix_sat(yl, c, zl, -s, r.clip);
                r.z = mix_sat(yl, s, zl, c, r.clip);
            end
            vrot_pkg::AXIS_Y: begin
                r.x = mix_sat(xl, c, zl, -s, r.clip);
                r.z = mix_sat(xl, s, zl, c, r.clip);
            end
            vrot_pkg::AXIS_Z: begin
                r.x = mix_sat(xl, c, yl, -s, r.clip);
                r.y = mix_sat(xl, s, yl, c, r.clip);
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic logic signed [vrot_pkg::COORD_W-1:0] rand_coord();
        case ($urandom_range(0, 7))
            0: return POS_MAX;
            1: return NEG_MAX;
            2: return POS_MAX - $urandom_range(0, 255);
            3, 4: return $signed($urandom_range(0, 262143)) - 131072;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [vrot_pkg::ANGLE_W-1:0] rand_angle();
        logic [vrot_pkg::ANGLE_W-1:0] a;
        if ($urandom_range(0, 3) == 0) begin
            a = {2'($urandom_range(0, 3)), 10'd0};
            a = vrot_pkg::ANGLE_W'(a + $urandom_range(0, 2) - 1);
        end else begin
            a = vrot_pkg::ANGLE_W'($urandom_range(0, 4095));
        end
        return a;
    endfunction

    task automatic send_vec(vrot_pkg::t_axis_op op, logic [vrot_pkg::ANGLE_W-1:0] ang,
                            logic signed [vrot_pkg::COORD_W-1:0] x,
                            logic signed [vrot_pkg::COORD_W-1:0] y,
                            logic signed [vrot_pkg::COORD_W-1:0] z,
                            bit known, t_rot_res res);
        t_known_rot k;
        k.known = known;
        k.res = res;
        known_rot_q.push_back(k);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {4'd0, z, y, x, ang};
        s_axis_tuser <= op;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
    endtask

    // hold off the sender until every expected beat is back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (rotated_q.size() != 0)
            @(posedge i_clk);
    endtask

    // output stall pattern, four modes chosen by rx_cnt[9:8]
    always @(posedge i_clk) begin
        rx_cnt <= rx_cnt + 1'b1;
        case (rx_cnt[9:8])
            2'd0: m_axis_tready <= 1'b1;
            2'd1: m_axis_tready <= ($urandom_range(0, 9) < 7);
            2'd2: m_axis_tready <= (rx_cnt[2:0] > 3'd2);
            default: m_axis_tready <= (rx_cnt[4:0] < 5'd20);
        endcase
    end

    always @(posedge i_clk) begin
        t_rot_res   got;
        t_rot_res   want;
        t_known_rot k;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.x = m_axis_tdata[31:0];
                got.y = m_axis_tdata[63:32];
                got.z = m_axis_tdata[95:64];
                got.clip = m_axis_tuser;
                if (rotated_q.size() == 0) begin
                    $error("result beat with no expectation waiting");
                    fail_cnt++;
                end else begin
                    want = rotated_q.pop_front();
                    if (got.x !== want.x) begin
                        $error("out_x: expected %0d, got %0d", want.x, got.x);
                        fail_cnt++;
                    end
                    if (got.y !== want.y) begin
                        $error("out_y: expected %0d, got %0d", want.y, got.y);
                        fail_cnt++;
                    end
                    if (got.z !== want.z) begin
                        $error("out_z: expected %0d, got %0d", want.z, got.z);
                        fail_cnt++;
                    end
                    if (got.clip !== want.clip) begin
                        $error("clipped: expected %0b, got %0b", want.clip, got.clip);
                        fail_cnt++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                k = known_rot_q.pop_front();
                if (k.known)
                    rotated_q.push_back(k.res);
                else
                    rotated_q.push_back(rotate_vec(vrot_pkg::t_axis_op'(s_axis_tuser),
                                                   s_axis_tdata[11:0], s_axis_tdata[43:12],
                                                   s_axis_tdata[75:44], s_axis_tdata[107:76]));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        int n;
        int burst;
        int gap;
        for (int i = 0; i <= vrot_pkg::QUARTER_TABLE_DEPTH; i++)
            sine_q15[i] = sine_point(64'(i));

        // quarter turns use the exact table ends 0 and 32768
        dir_rows = '{
            '{vrot_pkg::AXIS_PASS, 12'd123, POS_MAX, NEG_MAX, -32'sd1, 1'b1,
              '{POS_MAX, NEG_MAX, -32'sd1, 1'b0}},
            '{vrot_pkg::AXIS_X, 12'd0, 32'sd1, NEG_MAX, POS_MAX, 1'b1,
              '{32'sd1, NEG_MAX, POS_MAX, 1'b0}},
            '{vrot_pkg::AXIS_Y, 12'd0, NEG_MAX, 32'sd5, POS_MAX, 1'b1,
              '{NEG_MAX, 32'sd5, POS_MAX, 1'b0}},
            '{vrot_pkg::AXIS_Z, 12'd0, POS_MAX, NEG_MAX, 32'sd0, 1'b1,
              '{POS_MAX, NEG_MAX, 32'sd0, 1'b0}},
            '{vrot_pkg::AXIS_X, 12'd1024, 32'sd7, 32'sh1234_0000, NEG_MAX, 1'b1,
              '{32'sd7, POS_MAX, 32'sh1234_0000, 1'b1}},
            '{vrot_pkg::AXIS_Y, 12'd2048, NEG_MAX, 32'sd9, 32'sd100, 1'b1,
              '{POS_MAX, 32'sd9, -32'sd100, 1'b1}},
            '{vrot_pkg::AXIS_Z, 12'd3072, POS_MAX, NEG_MAX, 32'sd42, 1'b1,
              '{NEG_MAX, 32'sh8000_0001, 32'sd42, 1'b0}},
            '{vrot_pkg::AXIS_Z, 12'd1024, -32'sd1, 32'sd1, NEG_MAX, 1'b1,
              '{-32'sd1, -32'sd1, NEG_MAX, 1'b0}},
            '{vrot_pkg::AXIS_PASS, 12'd4095, 32'sd0, 32'sd0, 32'sd0, 1'b1,
              '{32'sd0, 32'sd0, 32'sd0, 1'b0}},
            '{vrot_pkg::AXIS_X, 12'd4095, POS_MAX, POS_MAX, POS_MAX, 1'b0, '0},
            '{vrot_pkg::AXIS_Y, 12'd512, POS_MAX, 32'sd0, NEG_MAX, 1'b0, '0},
            '{vrot_pkg::AXIS_Z, 12'd512, NEG_MAX, NEG_MAX, POS_MAX, 1'b0, '0},
            '{vrot_pkg::AXIS_X, 12'd1, 32'sd0, 32'sh0001_0000, -32'sh0001_0000, 1'b0, '0},
            '{vrot_pkg::AXIS_Y, 12'd1023, POS_MAX, -32'sd3, NEG_MAX, 1'b0, '0},
            '{vrot_pkg::AXIS_Z, 12'd1025, 32'sh0100_0000, NEG_MAX, 32'sd1, 1'b0, '0},
            '{vrot_pkg::AXIS_X, 12'd2047, -32'sd1, POS_MAX, POS_MAX, 1'b0, '0},
            '{vrot_pkg::AXIS_Y, 12'd2049, NEG_MAX, 32'sd0, NEG_MAX, 1'b0, '0},
            '{vrot_pkg::AXIS_Z, 12'd3071, POS_MAX, POS_MAX, -32'sd1, 1'b0, '0},
            '{vrot_pkg::AXIS_X, 12'd3073, 32'sd0, NEG_MAX, NEG_MAX, 1'b0, '0},
            '{vrot_pkg::AXIS_Y, 12'd2730, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh7FFF_0001,
              1'b0, '0}
        };

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i])
            send_vec(dir_rows[i].op, dir_rows[i].ang, dir_rows[i].x, dir_rows[i].y,
                     dir_rows[i].z, dir_rows[i].known, dir_rows[i].res);
        drain_results();

        n = 0;
        while (n < RAND_ITEMS) begin
            burst = $urandom_range(1, 24);
            for (int b = 0; b < burst && n < RAND_ITEMS; b++) begin
                send_vec(vrot_pkg::t_axis_op'($urandom_range(0, 3)), rand_angle(),
                         rand_coord(), rand_coord(), rand_coord(), 1'b0, '0);
                n++;
            end
            if (n >= RAND_ITEMS)
                break;
            if ($urandom_range(0, 19) == 0) begin
                drain_results();
            end else begin
                gap = $urandom_range(0, 6);
                if (gap > 0) begin
                    s_axis_tvalid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
        drain_results();
        repeat (8) @(posedge i_clk);

        if (fail_cnt == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
